/* hw/rtl/kli_pkg.sv */
// Shared types and constants for the key-point linear interpolator.
package kli_pkg;

  localparam int MAX_POINTS_DEF = 32;
  localparam int FRAME_BITS_DEF = 16;
  localparam int IN_FRAME_W     = 16;
  localparam int VAL_W          = 16;
  localparam int Q_W            = 16;

  typedef enum logic [1:0] {
    K_CLEAR  = 2'd0,
    K_INSERT = 2'd1,
    K_EVAL   = 2'd2,
    K_NONE   = 2'd3
  } kind_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
    logic  have_l;
    logic  have_r;
    logic  found;
  } ctl_t;

endpackage

/* hw/rtl/kli_cell.sv */
// One storage cell of the key-point chain: holds a point and updates the passing token.
module kli_cell #(
  parameter int FRAME_BITS = kli_pkg::FRAME_BITS_DEF,
  parameter int IDX_W      = 5,
  parameter int CELL_IDX   = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           occ,
  input  kli_pkg::ctl_t                  ctl_in,
  input  logic [FRAME_BITS-1:0]          f_in,
  input  logic signed [kli_pkg::VAL_W-1:0] kv_in,
  input  logic [FRAME_BITS-1:0]          lf_in,
  input  logic signed [kli_pkg::VAL_W-1:0] lv_in,
  input  logic [FRAME_BITS-1:0]          rf_in,
  input  logic signed [kli_pkg::VAL_W-1:0] rv_in,
  input  logic                           app_we,
  input  logic [IDX_W-1:0]               app_idx,
  input  logic [FRAME_BITS-1:0]          app_f,
  input  logic signed [kli_pkg::VAL_W-1:0] app_v,
  output kli_pkg::ctl_t                  ctl_out,
  output logic [FRAME_BITS-1:0]          f_out,
  output logic signed [kli_pkg::VAL_W-1:0] kv_out,
  output logic [FRAME_BITS-1:0]          lf_out,
  output logic signed [kli_pkg::VAL_W-1:0] lv_out,
  output logic [FRAME_BITS-1:0]          rf_out,
  output logic signed [kli_pkg::VAL_W-1:0] rv_out
);
  import kli_pkg::*;

  logic [FRAME_BITS-1:0]   pf;
  logic signed [VAL_W-1:0] pv;

  logic hit, ev, take_l, take_r, match;
  ctl_t ctl_next;
  logic [FRAME_BITS-1:0]   lf_next, rf_next;
  logic signed [VAL_W-1:0] lv_next, rv_next;

  always_comb begin
    hit    = ctl_in.valid && occ;
    ev     = hit && (ctl_in.kind == K_EVAL);
    take_l = ev && (pf <= f_in) && (!ctl_in.have_l || (pf > lf_in));
    take_r = ev && (pf >= f_in) && (!ctl_in.have_r || (pf < rf_in));
    match  = hit && (ctl_in.kind == K_INSERT) && (pf == f_in);

    ctl_next        = ctl_in;
    ctl_next.have_l = ctl_in.have_l || take_l;
    ctl_next.have_r = ctl_in.have_r || take_r;
    ctl_next.found  = ctl_in.found || match;
    lf_next         = take_l ? pf : lf_in;
    lv_next         = take_l ? pv : lv_in;
    rf_next         = take_r ? pf : rf_in;
    rv_next         = take_r ? pv : rv_in;
  end

  always_ff @(posedge clk) begin
    if (app_we && (app_idx == IDX_W'(CELL_IDX))) begin
      pf <= app_f;
      pv <= app_v;
    end else if (match) begin
      pv <= kv_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_next;
    end
    f_out  <= f_in;
    kv_out <= kv_in;
    lf_out <= lf_next;
    lv_out <= lv_next;
    rf_out <= rf_next;
    rv_out <= rv_next;
  end

endmodule

/* hw/rtl/kli_div.sv */
// Restoring divider, one quotient bit per cycle, for a quotient known to fit Q_W bits.
module kli_div #(
  parameter int FRAME_BITS = kli_pkg::FRAME_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [kli_pkg::Q_W+FRAME_BITS-1:0]    num,
  input  logic [FRAME_BITS-1:0]                 den,
  output logic                                  done,
  output logic [kli_pkg::Q_W-1:0]               quo
);
  import kli_pkg::*;

  localparam int CW = $clog2(Q_W + 1);

  logic                  busy;
  logic [CW-1:0]         cnt;
  logic [FRAME_BITS-1:0] rem;
  logic [Q_W-1:0]        lo;
  logic [FRAME_BITS:0]   t;
  logic [FRAME_BITS:0]   t_sub;
  logic                  ge;

  always_comb begin
    t     = {rem, lo[Q_W-1]};
    t_sub = t - {1'b0, den};
    ge    = t >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(Q_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // high part of num is below den, so the quotient fits Q_W bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num[Q_W+FRAME_BITS-1:Q_W];
      lo  <= num[Q_W-1:0];
      quo <= '0;
    end else if (busy) begin
      lo  <= {lo[Q_W-2:0], 1'b0};
      rem <= ge ? t_sub[FRAME_BITS-1:0] : t[FRAME_BITS-1:0];
      quo <= {quo[Q_W-2:0], ge};
    end
  end

endmodule

/* hw/rtl/keypoint_linear_interpolator.sv */
// Top level of the key-point linear interpolator: cell chain, multiply, divide, output register.
//
//  channel | signals                                   | dir | transaction
//  in      | in_valid, in_ready, kind, frame_index,    | in  | clear, insert or evaluate
//          | key_value                                 |     |
//  out     | out_valid, out_ready, shift_value, status | out | one result per input
//
// Clear and the unused kind go straight to the done state. Insert and evaluate pass
// down the chain of MAX_POINTS cells, one cell per cycle; an interpolating
// evaluate then passes through a multiply state and the divider. One item is in
// flight at a time; a new item is taken while the previous result waits in the
// output register.
// Reset empties the store at once; no clearing pass.
module keypoint_linear_interpolator #(
  parameter int MAX_POINTS = kli_pkg::MAX_POINTS_DEF,
  parameter int FRAME_BITS = kli_pkg::FRAME_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             kind,
  input  logic [kli_pkg::IN_FRAME_W-1:0]         frame_index,
  input  logic signed [kli_pkg::VAL_W-1:0]       key_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [kli_pkg::VAL_W-1:0]       shift_value,
  output logic                                   status
);
  import kli_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int PW    = Q_W + FRAME_BITS;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0] count;
  logic             full;
  logic             accept;
  kind_t            in_kind;

  ctl_t                    ctl_c [MAX_POINTS+1];
  logic [FRAME_BITS-1:0]   f_c   [MAX_POINTS+1];
  logic signed [VAL_W-1:0] kv_c  [MAX_POINTS+1];
  logic [FRAME_BITS-1:0]   lf_c  [MAX_POINTS+1];
  logic signed [VAL_W-1:0] lv_c  [MAX_POINTS+1];
  logic [FRAME_BITS-1:0]   rf_c  [MAX_POINTS+1];
  logic signed [VAL_W-1:0] rv_c  [MAX_POINTS+1];

  ctl_t                    ex;
  logic                    app_we;
  logic [IDX_W-1:0]        app_idx;

  logic [VAL_W:0]          diff;
  logic [VAL_W:0]          mag;
  logic                    neg;
  logic [FRAME_BITS-1:0]   df, dd;
  logic signed [VAL_W-1:0] lv_r;
  logic [PW-1:0]           prod;
  logic                    div_start;
  logic                    div_done;
  logic [Q_W-1:0]          quo;
  logic [VAL_W-1:0]        q_s;
  logic signed [VAL_W-1:0] res;
  logic                    res_status;

  assign in_kind  = kind_t'(kind);
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign full     = (count == CNT_W'(MAX_POINTS));

  always_comb begin
    ctl_c[0]        = '0;
    ctl_c[0].valid  = accept && ((in_kind == K_INSERT) || (in_kind == K_EVAL));
    ctl_c[0].kind   = in_kind;
    f_c[0]          = FRAME_BITS'(frame_index);
    kv_c[0]         = key_value;
    lf_c[0]         = '0;
    lv_c[0]         = '0;
    rf_c[0]         = '0;
    rv_c[0]         = '0;
  end

  assign ex      = ctl_c[MAX_POINTS];
  assign app_we  = (state == S_SCAN) && ex.valid && (ex.kind == K_INSERT) && !ex.found && !full;
  assign app_idx = count[IDX_W-1:0];

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    kli_cell #(
      .FRAME_BITS (FRAME_BITS),
      .IDX_W      (IDX_W),
      .CELL_IDX   (k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .occ     (CNT_W'(k) < count),
      .ctl_in  (ctl_c[k]),
      .f_in    (f_c[k]),
      .kv_in   (kv_c[k]),
      .lf_in   (lf_c[k]),
      .lv_in   (lv_c[k]),
      .rf_in   (rf_c[k]),
      .rv_in   (rv_c[k]),
      .app_we  (app_we),
      .app_idx (app_idx),
      .app_f   (f_c[MAX_POINTS]),
      .app_v   (kv_c[MAX_POINTS]),
      .ctl_out (ctl_c[k+1]),
      .f_out   (f_c[k+1]),
      .kv_out  (kv_c[k+1]),
      .lf_out  (lf_c[k+1]),
      .lv_out  (lv_c[k+1]),
      .rf_out  (rf_c[k+1]),
      .rv_out  (rv_c[k+1])
    );
  end

  assign diff = {rv_c[MAX_POINTS][VAL_W-1], rv_c[MAX_POINTS]}
              - {lv_c[MAX_POINTS][VAL_W-1], lv_c[MAX_POINTS]};

  // product of magnitude and an offset below the span; it always fits the PW bits kept
  assign prod = PW'(mag * df);

  kli_div #(
    .FRAME_BITS (FRAME_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod),
    .den   (dd),
    .done  (div_done),
    .quo   (quo)
  );

  assign q_s = neg ? (VAL_W'(0) - quo) : quo;

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if ((in_kind == K_INSERT) || (in_kind == K_EVAL)) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (ex.valid) begin
          if ((ex.kind == K_EVAL) && ex.have_l && ex.have_r
              && (lf_c[MAX_POINTS] != rf_c[MAX_POINTS])) begin
            state_next = S_MUL;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_MUL: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && (in_kind == K_CLEAR)) begin
        count <= '0;
      end else if (app_we) begin
        count <= count + CNT_W'(1);
      end
      if ((state == S_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      res        <= '0;
      res_status <= 1'b0;
    end
    if ((state == S_SCAN) && ex.valid) begin
      res_status <= (ex.kind == K_INSERT) && !ex.found && full;
      neg        <= diff[VAL_W];
      mag        <= diff[VAL_W] ? (~diff + (VAL_W+1)'(1)) : diff;
      df         <= f_c[MAX_POINTS] - lf_c[MAX_POINTS];
      dd         <= rf_c[MAX_POINTS] - lf_c[MAX_POINTS];
      lv_r       <= lv_c[MAX_POINTS];
      if (ex.kind == K_EVAL) begin
        if (!ex.have_l) begin
          res <= rv_c[MAX_POINTS];
        end else begin
          res <= lv_c[MAX_POINTS];
        end
      end
    end
    if ((state == S_DIV) && div_done) begin
      res <= lv_r + $signed(q_s);
    end
    if ((state == S_DONE) && (!out_valid || out_ready)) begin
      shift_value <= res;
      status      <= res_status;
    end
  end

endmodule

/* hw/rtl/kli_chk.sv */
// Port-level checker for the key-point linear interpolator, bound to the top level.
module kli_chk (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic [1:0]                             kind,
  input logic [kli_pkg::IN_FRAME_W-1:0]         frame_index,
  input logic signed [kli_pkg::VAL_W-1:0]       key_value,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [kli_pkg::VAL_W-1:0]       shift_value,
  input logic                                   status
);
  import kli_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(shift_value) && $stable(status))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while one is in flight");

  a_status_zero_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> shift_value == '0)
    else $error("dropped insert carries a nonzero value");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind keypoint_linear_interpolator kli_chk u_kli_chk (.*);
